// ===== src/sle_pkg.sv =====
// Shared constants, types and codes of the sequential list engine.
package sle_pkg;

    localparam int CAPACITY = 32;
    localparam int DATA_W   = 32;
    localparam int CMD_W    = 3;
    localparam int IDX_W    = 5;
    localparam int POS_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CNT_W > IDX_W) ? CNT_W + 1 : IDX_W + 1;
    localparam int FIND_W   = 5;
    localparam int LEN_W    = 6;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 48;

    localparam logic [CMD_W-1:0] CMD_SET    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LOCATE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_PRIOR  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_NEXT   = 3'd6;

    localparam logic [1:0] OP_HOLD       = 2'd0;
    localparam logic [1:0] OP_WRITE      = 2'd1;
    localparam logic [1:0] OP_SHIFT_UP   = 2'd2;
    localparam logic [1:0] OP_SHIFT_DOWN = 2'd3;

    typedef logic [DATA_W-1:0] data_t;
    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [CMP_W-1:0]  cmp_t;
    typedef logic [CAPACITY-1:0][DATA_W-1:0] ent_vec_t;

    typedef struct packed {
        logic             load;
        logic [1:0]       op;
        logic [IDX_W-1:0] index;
        data_t            value;
    } cell_ctrl_t;

    typedef struct packed {
        logic  found;
        pos_t  first_pos;
        logic  prior_ok;
        data_t prior_val;
        logic  next_ok;
        data_t next_val;
    } pick_t;

endpackage

// ===== src/sle_cell.sv =====
// One list position: holds an entry, shifts to or from its neighbors, flags a match.
module sle_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  sle_pkg::cell_ctrl_t ctrl,
    input  sle_pkg::pos_t      cell_pos,
    input  sle_pkg::cnt_t      count,
    input  sle_pkg::data_t     prev_entry,
    input  sle_pkg::data_t     next_entry,
    output sle_pkg::data_t     entry,
    output logic               hit
);

    sle_pkg::data_t entry_reg;
    sle_pkg::data_t entry_next;
    logic           hit_reg;
    logic           hit_next;
    logic           at_idx;
    logic           above_idx;
    logic           live;

    assign at_idx    = sle_pkg::cmp_t'(cell_pos) == sle_pkg::cmp_t'(ctrl.index);
    assign above_idx = sle_pkg::cmp_t'(cell_pos) >  sle_pkg::cmp_t'(ctrl.index);
    assign live      = sle_pkg::cmp_t'(cell_pos) <  sle_pkg::cmp_t'(count);

    always_comb begin
        entry_next = entry_reg;
        case (ctrl.op)
            sle_pkg::OP_WRITE: begin
                if (at_idx) entry_next = ctrl.value;
            end
            sle_pkg::OP_SHIFT_UP: begin
                if (above_idx)   entry_next = prev_entry;
                else if (at_idx) entry_next = ctrl.value;
            end
            sle_pkg::OP_SHIFT_DOWN: begin
                if (at_idx || above_idx) entry_next = next_entry;
            end
            default: entry_next = entry_reg;
        endcase
    end

    assign hit_next = ctrl.load ? (live && entry_reg == ctrl.value) : hit_reg;

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else begin
            hit_reg <= hit_next;
        end
    end

    assign entry = entry_reg;
    assign hit   = hit_reg;

endmodule

// ===== src/sle_pick.sv =====
// First-match isolation, position encode and neighbor selection over the cell row.
module sle_pick (
    input  logic [sle_pkg::CAPACITY-1:0] hits,
    input  sle_pkg::ent_vec_t            entries,
    input  sle_pkg::cnt_t                count,
    output sle_pkg::pick_t               pick
);

    logic [sle_pkg::CAPACITY-1:0] first;
    sle_pkg::pos_t                pos;
    sle_pkg::data_t               prior_val;
    sle_pkg::data_t               next_val;

    assign first = hits & (~hits + sle_pkg::CAPACITY'(1));

    always_comb begin
        pos       = '0;
        prior_val = '0;
        next_val  = '0;
        for (int i = 0; i < sle_pkg::CAPACITY; i++) begin
            if (first[i]) pos = pos | sle_pkg::pos_t'(i);
        end
        for (int i = 1; i < sle_pkg::CAPACITY; i++) begin
            if (first[i]) prior_val = prior_val | entries[i-1];
        end
        for (int i = 0; i < sle_pkg::CAPACITY - 1; i++) begin
            if (first[i]) next_val = next_val | entries[i+1];
        end
    end

    always_comb begin
        pick.found     = |hits;
        pick.first_pos = pos;
        pick.prior_ok  = (|hits) && !first[0];
        pick.prior_val = prior_val;
        pick.next_ok   = (|hits) &&
                         (sle_pkg::cmp_t'(pos) + sle_pkg::cmp_t'(1) < sle_pkg::cmp_t'(count));
        pick.next_val  = next_val;
    end

endmodule

// ===== src/sequential_list_engine_unit.sv =====
// Top level of the sequential list engine: command decode, cell row, result register.
// An accepted beat waits in the pending registers, then moves to the result register
// once that is free. A new beat is taken only after the pending one retires; retiring
// resolves the first match registered by the cells, and a stalled result holds the next beat back.
// Reset: aresetn clears the length, the in-flight flag and m_tvalid; entries
// are not cleared and only positions below the length are ever read.
module sequential_list_engine_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // cmd[2:0], index[7:3], value[39:8]
    input  logic [sle_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status[0], data_out[32:1], found_index[37:33], length_now[43:38], zero[47:44]
    output logic [sle_pkg::M_DATA_W-1:0]  m_tdata
);

    logic [sle_pkg::CMD_W-1:0] s_cmd;
    logic [sle_pkg::IDX_W-1:0] s_index;
    sle_pkg::data_t            s_value;

    assign s_cmd   = s_tdata[2:0];
    assign s_index = s_tdata[7:3];
    assign s_value = s_tdata[39:8];

    sle_pkg::cnt_t            count_reg, count_next;
    logic                     pend_reg, pend_next;
    logic [sle_pkg::CMD_W-1:0] pend_cmd_reg, pend_cmd_next;
    logic                     pend_err_reg, pend_err_next;
    sle_pkg::data_t           pend_data_reg, pend_data_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     out_err_reg, out_err_next;
    sle_pkg::data_t           out_data_reg, out_data_next;
    logic [sle_pkg::FIND_W-1:0] out_find_reg, out_find_next;
    logic [sle_pkg::LEN_W-1:0]  out_len_reg, out_len_next;

    sle_pkg::cell_ctrl_t          ctrl;
    sle_pkg::ent_vec_t            entries;
    logic [sle_pkg::CAPACITY-1:0] hits;
    sle_pkg::pick_t               pick;

    logic          accept;
    logic          retire;
    sle_pkg::cmp_t idx_c;
    sle_pkg::cmp_t cnt_c;
    logic          full;
    logic          in_range;
    logic          err1;
    logic [1:0]    op1;
    sle_pkg::cnt_t cnt1;
    sle_pkg::data_t rd_data;

    assign s_tready = !pend_reg;
    assign accept   = s_tvalid && s_tready;
    assign retire   = pend_reg && (!out_valid_reg || m_tready);

    assign idx_c    = sle_pkg::cmp_t'(s_index);
    assign cnt_c    = sle_pkg::cmp_t'(count_reg);
    assign full     = count_reg == sle_pkg::cnt_t'(sle_pkg::CAPACITY);
    assign in_range = idx_c < cnt_c;
    assign rd_data  = entries[sle_pkg::pos_t'(s_index)];

    always_comb begin
        err1 = 1'b1;
        op1  = sle_pkg::OP_HOLD;
        cnt1 = count_reg;
        unique case (s_cmd)
            sle_pkg::CMD_SET: begin
                if (in_range) begin
                    err1 = 1'b0;
                    op1  = sle_pkg::OP_WRITE;
                end else if (idx_c == cnt_c && !full) begin
                    err1 = 1'b0;
                    op1  = sle_pkg::OP_WRITE;
                    cnt1 = count_reg + sle_pkg::cnt_t'(1);
                end
            end
            sle_pkg::CMD_GET: begin
                err1 = !in_range;
            end
            sle_pkg::CMD_INSERT: begin
                if (idx_c <= cnt_c && !full) begin
                    err1 = 1'b0;
                    op1  = sle_pkg::OP_SHIFT_UP;
                    cnt1 = count_reg + sle_pkg::cnt_t'(1);
                end
            end
            sle_pkg::CMD_DELETE: begin
                if (in_range) begin
                    err1 = 1'b0;
                    op1  = sle_pkg::OP_SHIFT_DOWN;
                    cnt1 = count_reg - sle_pkg::cnt_t'(1);
                end
            end
            default: err1 = 1'b1;
        endcase
    end

    always_comb begin
        ctrl.load  = accept;
        ctrl.op    = accept ? op1 : sle_pkg::OP_HOLD;
        ctrl.index = s_index;
        ctrl.value = s_value;
    end

    genvar gi;
    generate
        for (gi = 0; gi < sle_pkg::CAPACITY; gi++) begin : g_cell
            sle_pkg::data_t prev_e;
            sle_pkg::data_t next_e;
            if (gi == 0) begin : g_first
                assign prev_e = '0;
            end else begin : g_prev
                assign prev_e = entries[gi-1];
            end
            if (gi == sle_pkg::CAPACITY - 1) begin : g_last
                assign next_e = '0;
            end else begin : g_next
                assign next_e = entries[gi+1];
            end
            sle_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .cell_pos   (sle_pkg::pos_t'(gi)),
                .count      (count_reg),
                .prev_entry (prev_e),
                .next_entry (next_e),
                .entry      (entries[gi]),
                .hit        (hits[gi])
            );
        end
    endgenerate

    sle_pick u_pick (
        .hits    (hits),
        .entries (entries),
        .count   (count_reg),
        .pick    (pick)
    );

    always_comb begin
        count_next     = accept ? cnt1 : count_reg;
        pend_next      = accept ? 1'b1 : (retire ? 1'b0 : pend_reg);
        pend_cmd_next  = accept ? s_cmd : pend_cmd_reg;
        pend_err_next  = accept ? err1 : pend_err_reg;
        pend_data_next = pend_data_reg;
        if (accept) begin
            pend_data_next = (!err1 && (s_cmd == sle_pkg::CMD_GET || s_cmd == sle_pkg::CMD_DELETE))
                             ? rd_data : '0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_err_next   = out_err_reg;
        out_data_next  = out_data_reg;
        out_find_next  = out_find_reg;
        out_len_next   = out_len_reg;
        if (out_valid_reg && m_tready) out_valid_next = 1'b0;
        if (retire) begin
            out_valid_next = 1'b1;
            out_len_next   = sle_pkg::LEN_W'(count_reg);
            out_find_next  = '0;
            unique case (pend_cmd_reg)
                sle_pkg::CMD_LOCATE: begin
                    out_err_next  = !pick.found;
                    out_data_next = '0;
                    if (pick.found) out_find_next = sle_pkg::FIND_W'(pick.first_pos);
                end
                sle_pkg::CMD_PRIOR: begin
                    out_err_next  = !pick.prior_ok;
                    out_data_next = pick.prior_ok ? pick.prior_val : '0;
                end
                sle_pkg::CMD_NEXT: begin
                    out_err_next  = !pick.next_ok;
                    out_data_next = pick.next_ok ? pick.next_val : '0;
                end
                default: begin
                    out_err_next  = pend_err_reg;
                    out_data_next = pend_data_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_cmd_reg  <= pend_cmd_next;
        pend_err_reg  <= pend_err_next;
        pend_data_reg <= pend_data_next;
        out_err_reg   <= out_err_next;
        out_data_reg  <= out_data_next;
        out_find_reg  <= out_find_next;
        out_len_reg   <= out_len_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_len_reg, out_find_reg, out_data_reg, out_err_reg};

endmodule

// ===== test/sequential_list_engine_unit_test.sv =====
// Self-checking testbench for the sequential list engine: random command beats, field checks.
module sequential_list_engine_unit_test;
    import sle_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
    localparam int RANDOM_BEATS = 950;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE       = 10;
    localparam int REPORT_MAX   = 10;

    typedef struct {
        logic [CMD_W-1:0] op;
        logic [IDX_W-1:0] idx;
        data_t            val;
        int unsigned      gap;
    } list_cmd_t;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [FIND_W-1:0] found;
        data_t             data;
        logic              status;
    } list_result_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    list_cmd_t    command_queue[$];
    list_result_t results_due[$];
    data_t        shadow_entries[CAPACITY];
    int           shadow_len = 0;
    data_t        value_pool[8];

    int  plan_len = 0;
    int  beats_total = 0;
    int  beats_taken = 0;
    int  results_taken = 0;
    int  mismatches = 0;
    int  cycle_count = 0;
    logic in_fire = 1'b0;
    logic out_fire = 1'b0;
    int  wait_left = 0;
    bit  gap_armed = 1'b0;
    int  stall_left = 0;

    sequential_list_engine_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    function automatic int draw_gap(int serial);
        if ((serial / 64) % 4 == 3) begin
            return 0;
        end
        return $urandom_range(0, 3);
    endfunction

    function automatic int pick_below(int len);
        return (len == 0) ? 0 : $urandom_range(0, len - 1);
    endfunction

    function automatic int pick_upto(int len);
        return $urandom_range(0, (len > 31) ? 31 : len);
    endfunction

    function automatic data_t pick_value();
        if ($urandom_range(0, 9) < 6) begin
            return value_pool[$urandom_range(0, 7)];
        end
        return $urandom;
    endfunction

    // Apply one command to the shadow list and return the beat it produces.
    function automatic list_result_t run_list_command(logic [CMD_W-1:0] op,
                                                      logic [IDX_W-1:0] idx, data_t val);
        list_result_t res;
        int  pos;
        bit  hit;
        res = '0;
        res.status = 1'b1;
        pos = 0;
        hit = 1'b0;
        for (int i = 0; i < shadow_len; i++) begin
            if (!hit && shadow_entries[i] == val) begin
                hit = 1'b1;
                pos = i;
            end
        end
        case (op)
            CMD_SET: begin
                if (idx < shadow_len) begin
                    shadow_entries[idx] = val;
                    res.status = 1'b0;
                end else if (idx == shadow_len && shadow_len < CAPACITY) begin
                    shadow_entries[idx] = val;
                    shadow_len++;
                    res.status = 1'b0;
                end
            end
            CMD_GET: begin
                if (idx < shadow_len) begin
                    res.data = shadow_entries[idx];
                    res.status = 1'b0;
                end
            end
            CMD_INSERT: begin
                if (idx <= shadow_len && shadow_len < CAPACITY) begin
                    for (int i = shadow_len; i > idx; i--) begin
                        shadow_entries[i] = shadow_entries[i - 1];
                    end
                    shadow_entries[idx] = val;
                    shadow_len++;
                    res.status = 1'b0;
                end
            end
            CMD_DELETE: begin
                if (idx < shadow_len) begin
                    res.data = shadow_entries[idx];
                    for (int i = idx; i + 1 < shadow_len; i++) begin
                        shadow_entries[i] = shadow_entries[i + 1];
                    end
                    shadow_len--;
                    res.status = 1'b0;
                end
            end
            CMD_LOCATE: begin
                if (hit) begin
                    res.found = pos[FIND_W-1:0];
                    res.status = 1'b0;
                end
            end
            CMD_PRIOR: begin
                if (hit && pos > 0) begin
                    res.data = shadow_entries[pos - 1];
                    res.status = 1'b0;
                end
            end
            CMD_NEXT: begin
                if (hit && pos + 1 < shadow_len) begin
                    res.data = shadow_entries[pos + 1];
                    res.status = 1'b0;
                end
            end
            default: begin
            end
        endcase
        res.len = shadow_len[LEN_W-1:0];
        return res;
    endfunction

    // Queue a command beat and track the length it leaves behind.
    task automatic queue_command(logic [CMD_W-1:0] op, int idx, data_t val);
        list_cmd_t c;
        c.op  = op;
        c.idx = idx[IDX_W-1:0];
        c.val = val;
        c.gap = draw_gap(beats_total);
        command_queue.push_back(c);
        beats_total++;
        case (op)
            CMD_SET:    if (idx == plan_len && plan_len < CAPACITY) plan_len++;
            CMD_INSERT: if (idx <= plan_len && plan_len < CAPACITY) plan_len++;
            CMD_DELETE: if (idx < plan_len) plan_len--;
            default: begin
            end
        endcase
    endtask

    task automatic flag_mismatch(string field, logic [M_DATA_W-1:0] want,
                                 logic [M_DATA_W-1:0] got);
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
            $display("mismatch in %s at cycle %0d: expected %h, got %h",
                     field, cycle_count, want, got);
        end
    endtask

    // Driver: present queued beats with a per-beat gap, hold until taken.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_fire) begin
            if (!gap_armed && command_queue.size() != 0) begin
                wait_left = command_queue[0].gap;
                gap_armed = 1'b1;
            end
            if (gap_armed && wait_left == 0) begin
                s_tdata  <= {command_queue[0].val, command_queue[0].idx, command_queue[0].op};
                s_tvalid <= 1'b1;
                void'(command_queue.pop_front());
                gap_armed = 1'b0;
            end else begin
                s_tvalid <= 1'b0;
                if (gap_armed) wait_left--;
            end
        end
    end

    // Sink: stall a random number of cycles before taking each result beat.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (!m_tready || out_fire) begin
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                stall_left = draw_gap(results_taken);
            end
        end
    end

    // Monitor: update the shadow list on each command beat, check each result beat.
    always @(posedge aclk) begin : beat_monitor
        list_result_t due;
        cycle_count++;
        if (!aresetn) begin
            in_fire  <= 1'b0;
            out_fire <= 1'b0;
        end else begin
            in_fire  <= s_tvalid && s_tready;
            out_fire <= m_tvalid && m_tready;
            if (m_tvalid && m_tready) begin
                results_taken++;
                if (results_due.size() == 0) begin
                    flag_mismatch("unexpected beat", '0, m_tdata);
                end else begin
                    due = results_due.pop_front();
                    if (m_tdata[0] !== due.status)
                        flag_mismatch("status", M_DATA_W'(due.status),
                                      M_DATA_W'(m_tdata[0]));
                    if (m_tdata[32:1] !== due.data)
                        flag_mismatch("data_out", M_DATA_W'(due.data),
                                      M_DATA_W'(m_tdata[32:1]));
                    if (m_tdata[37:33] !== due.found)
                        flag_mismatch("found_index", M_DATA_W'(due.found),
                                      M_DATA_W'(m_tdata[37:33]));
                    if (m_tdata[43:38] !== due.len)
                        flag_mismatch("length_now", M_DATA_W'(due.len),
                                      M_DATA_W'(m_tdata[43:38]));
                    if (m_tdata[47:44] !== 4'b0)
                        flag_mismatch("pad", '0, M_DATA_W'(m_tdata[47:44]));
                end
            end
            if (s_tvalid && s_tready) begin
                results_due.push_back(run_list_command(s_tdata[2:0], s_tdata[7:3],
                                                       s_tdata[39:8]));
                beats_taken++;
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("** sequential_list_engine_unit: FAILED **");
        $finish;
    end

    initial begin : stimulus
        int  r;
        int  idx;
        bit  growing;
        logic [CMD_W-1:0] op;
        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        value_pool[2] = 32'h8000_0000;
        value_pool[3] = 32'h7FFF_FFFF;
        value_pool[4] = 32'h0000_0001;
        value_pool[5] = $urandom;
        value_pool[6] = $urandom;
        value_pool[7] = $urandom;

        // empty list: reads, deletes and searches fail
        queue_command(CMD_GET, 0, 32'h0);
        queue_command(CMD_DELETE, 0, 32'h0);
        queue_command(CMD_LOCATE, 0, 32'h5);
        queue_command(CMD_PRIOR, 0, 32'h5);
        queue_command(CMD_NEXT, 31, 32'h5);
        queue_command(CMD_SET, 1, 32'h1);
        // append, append by insert, insert in front, insert past the end
        queue_command(CMD_SET, 0, 32'h8000_0000);
        queue_command(CMD_INSERT, 1, 32'h7FFF_FFFF);
        queue_command(CMD_INSERT, 0, 32'h0);
        queue_command(CMD_INSERT, 31, 32'h1);
        queue_command(CMD_SET, 2, 32'hFFFF_FFFF);
        queue_command(CMD_GET, 2, 32'h0);
        queue_command(CMD_GET, 31, 32'h0);
        queue_command(CMD_LOCATE, 0, 32'hFFFF_FFFF);
        queue_command(CMD_LOCATE, 0, 32'h1234_5678);
        // no neighbour before the head or after the tail; inner neighbours are found
        queue_command(CMD_PRIOR, 0, 32'h0);
        queue_command(CMD_NEXT, 0, 32'hFFFF_FFFF);
        queue_command(CMD_PRIOR, 0, 32'hFFFF_FFFF);
        queue_command(CMD_NEXT, 0, 32'h0);
        queue_command(CMD_UNUSED, 31, 32'hFFFF_FFFF);
        queue_command(CMD_DELETE, 0, 32'h0);
        queue_command(CMD_DELETE, 5, 32'h0);
        queue_command(CMD_DELETE, 1, 32'h0);
        queue_command(CMD_GET, 0, 32'h0);

        // fill toward full, drain toward empty, with noise mixed in
        growing = 1'b1;
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                op  = growing ? CMD_INSERT : CMD_DELETE;
                idx = growing ? pick_upto(plan_len) : pick_below(plan_len);
            end else if (r < 52) begin
                op  = CMD_SET;
                idx = (growing && plan_len < CAPACITY) ? plan_len : pick_below(plan_len);
            end else if (r < 60) begin
                op  = growing ? CMD_DELETE : CMD_INSERT;
                idx = growing ? pick_below(plan_len) : pick_upto(plan_len);
            end else if (r < 68) begin
                op  = CMD_GET;
                idx = pick_below(plan_len);
            end else if (r < 90) begin
                op  = CMD_LOCATE + CMD_W'($urandom_range(0, 2));
                idx = $urandom_range(0, 31);
            end else begin
                op  = CMD_W'($urandom_range(0, 7));
                idx = $urandom_range(0, 31);
            end
            queue_command(op, idx, pick_value());
            if (growing && plan_len == CAPACITY && $urandom_range(0, 9) == 0) begin
                growing = 1'b0;
            end else if (!growing && plan_len == 0 && $urandom_range(0, 9) == 0) begin
                growing = 1'b1;
            end else if ($urandom_range(0, 49) == 0) begin
                growing = !growing;
            end
        end

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        while (beats_taken < beats_total || results_due.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("** sequential_list_engine_unit: PASSED **");
        end else begin
            $display("** sequential_list_engine_unit: FAILED **");
        end
        $finish;
    end

endmodule
